/* sv/sobel_edge_magnitude_rgb_assert.svh */
// Assertion macros for the Sobel edge magnitude block.
`ifndef SOBEL_EDGE_MAGNITUDE_RGB_ASSERT_SVH
`define SOBEL_EDGE_MAGNITUDE_RGB_ASSERT_SVH

// Same-cycle implication, checked at every rising clock edge out of reset.
`define SEM_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define SEM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/sem_pkg.sv */
// Shared types and constants of the Sobel edge magnitude block.
package sem_pkg;

	localparam int CH_W     = 8;
	localparam int PX_W     = 3 * CH_W;
	localparam int GRAD_W   = 12;
	localparam int SUM_W    = 22;
	localparam int PROD_W   = 2 * CH_W;
	localparam int FW_W     = 11;
	localparam int FH_W     = 16;
	localparam int CFG_W    = 16;
	localparam int ROOT_LAST = CH_W - 1;

	localparam logic [FW_W-1:0] RESET_WIDTH  = FW_W'(640);
	localparam logic [FH_W-1:0] RESET_HEIGHT = FH_W'(480);

	localparam logic REG_FRAME_WIDTH  = 1'b0;
	localparam logic REG_FRAME_HEIGHT = 1'b1;

	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_DRAIN = 1'b1;

	typedef struct packed {
		logic cfg_wr;
		logic accept;
		logic eff;
		logic mul;
		logic clamp;
		logic div_step;
		logic push;
		logic grad;
		logic square;
		logic root_step;
		logic load_out;
	} ctl_t;

	typedef struct packed {
		logic drain_skip;
		logic emit;
		logic div_done;
		logic root_done;
		logic out_free;
	} stat_t;

endpackage

/* sv/sem_ctrl.sv */
// Controller state machine of the Sobel edge magnitude block.
module sem_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic          cfg_valid,
	input  sem_pkg::stat_t stat,
	output sem_pkg::ctl_t  ctl,
	output logic          in_ready,
	output logic          cfg_ready
);

	typedef enum logic [3:0] {
		ST_EFF, ST_MUL, ST_CLAMP, ST_DIV, ST_IDLE,
		ST_PUSH, ST_GRAD, ST_SQUARE, ST_ROOT, ST_OUT
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_EFF;
		end else begin
			case (state_q)
				ST_EFF:    state_q <= ST_MUL;
				ST_MUL:    state_q <= ST_CLAMP;
				ST_CLAMP:  state_q <= ST_DIV;
				ST_DIV:    if (stat.div_done) state_q <= ST_IDLE;
				ST_IDLE: begin
					if (cfg_valid) state_q <= ST_EFF;
					else if (in_valid && !stat.drain_skip) state_q <= ST_PUSH;
				end
				ST_PUSH:   state_q <= stat.emit ? ST_GRAD : ST_IDLE;
				ST_GRAD:   state_q <= ST_SQUARE;
				ST_SQUARE: state_q <= ST_ROOT;
				ST_ROOT:   if (stat.root_done) state_q <= ST_OUT;
				ST_OUT:    if (stat.out_free) state_q <= ST_IDLE;
				default:   state_q <= ST_EFF;
			endcase
		end
	end

	always_comb begin
		ctl           = '0;
		ctl.cfg_wr    = (state_q == ST_IDLE) && cfg_valid;
		ctl.accept    = (state_q == ST_IDLE) && !cfg_valid && in_valid;
		ctl.eff       = (state_q == ST_EFF);
		ctl.mul       = (state_q == ST_MUL);
		ctl.clamp     = (state_q == ST_CLAMP);
		ctl.div_step  = (state_q == ST_DIV);
		ctl.push      = (state_q == ST_PUSH);
		ctl.grad      = (state_q == ST_GRAD);
		ctl.square    = (state_q == ST_SQUARE);
		ctl.root_step = (state_q == ST_ROOT);
		ctl.load_out  = (state_q == ST_OUT) && stat.out_free;
	end

	assign cfg_ready = (state_q == ST_IDLE);
	assign in_ready  = (state_q == ST_IDLE) && !cfg_valid;

endmodule

/* sv/sem_dpath.sv */
// Datapath: line stores, window, gradients, root search and position counters.
module sem_dpath #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  sem_pkg::ctl_t              ctl,
	output sem_pkg::stat_t             stat,
	input  logic                       in_op,
	input  logic [sem_pkg::PX_W-1:0]   in_px,
	input  logic                       cfg_index,
	input  logic [sem_pkg::CFG_W-1:0]  cfg_data,
	output logic [sem_pkg::CH_W-1:0]   out_red,
	output logic [sem_pkg::CH_W-1:0]   out_green,
	output logic [sem_pkg::CH_W-1:0]   out_blue,
	output logic                       out_last,
	output logic                       out_valid,
	input  logic                       out_ready
);

	localparam int CW  = $clog2(MAX_WIDTH);
	localparam int WBW = $clog2(MAX_WIDTH + 1);
	localparam int EW  = (WBW > sem_pkg::FW_W) ? WBW : sem_pkg::FW_W;
	localparam int PW  = EW + 1;
	localparam int TW  = EW + sem_pkg::FH_W;
	localparam int DCW = $clog2(TW);
	localparam int CH_W = sem_pkg::CH_W;

	logic [sem_pkg::FW_W-1:0] frame_width_q;
	logic [sem_pkg::FH_W-1:0] frame_height_q;
	logic [EW-1:0]            w_eff_q;
	logic [sem_pkg::FH_W-1:0] h_eff_q;
	logic [TW-1:0]            total_q;
	logic [TW-1:0]            idx_q;
	logic [CW-1:0]            col_q;
	logic [PW-1:0]            pending_q;
	logic [sem_pkg::FH_W-1:0] orow_q;
	logic [CW-1:0]            ocol_q;
	logic [TW-1:0]            quo_q;
	logic [EW-1:0]            rem_q;
	logic [DCW-1:0]           div_cnt_q;
	logic                     op_q;
	logic [sem_pkg::PX_W-1:0] px_q;

	logic [sem_pkg::PX_W-1:0] upper_mem  [MAX_WIDTH];
	logic [sem_pkg::PX_W-1:0] middle_mem [MAX_WIDTH];
	logic [sem_pkg::PX_W-1:0] up_rd_q, mid_rd_q;
	logic [sem_pkg::PX_W-1:0] win_q [3][3];

	logic signed [sem_pkg::GRAD_W-1:0] gx_s1 [3];
	logic signed [sem_pkg::GRAD_W-1:0] gy_s1 [3];
	logic                              last_s1;
	logic [sem_pkg::SUM_W-1:0]         sum_s2 [3];
	logic [CH_W-1:0]                   root_q [3];
	logic [$clog2(CH_W)-1:0]           root_bit_q;
	logic                              out_valid_q;

	logic [EW-1:0]            w_calc;
	logic [sem_pkg::FH_W-1:0] h_calc;
	logic [PW-1:0]            lag;
	logic [sem_pkg::PX_W-1:0] push_px;
	logic [EW:0]              rem_sh;
	logic                     div_ge;
	logic [EW:0]              rem_sub;
	logic [TW-1:0]            quo_n;
	logic [EW-1:0]            rem_n;
	logic                     m_top, m_bottom, m_left, m_right;
	logic signed [sem_pkg::GRAD_W-1:0] gx_c [3];
	logic signed [sem_pkg::GRAD_W-1:0] gy_c [3];
	logic signed [sem_pkg::GRAD_W-1:0] v [3][3];
	logic [CH_W-1:0]                   try_c [3];
	logic [sem_pkg::PROD_W-1:0]        prod_c [3];

	always_comb begin
		w_calc = EW'(frame_width_q);
		if (frame_width_q == '0) w_calc = EW'(1);
		else if (EW'(frame_width_q) > EW'(MAX_WIDTH)) w_calc = EW'(MAX_WIDTH);
		h_calc = (frame_height_q == '0) ? sem_pkg::FH_W'(1) : frame_height_q;
	end

	assign lag     = PW'(w_eff_q) + PW'(1);
	assign push_px = (op_q == sem_pkg::OP_DRAIN) ? '0 : px_q;

	assign rem_sh  = {rem_q, quo_q[TW-1]};
	assign div_ge  = rem_sh >= {1'b0, w_eff_q};
	assign rem_sub = div_ge ? (rem_sh - {1'b0, w_eff_q}) : rem_sh;
	assign rem_n   = rem_sub[EW-1:0];
	assign quo_n   = {quo_q[TW-2:0], div_ge};

	assign m_top    = (orow_q == '0);
	assign m_bottom = (orow_q == h_eff_q - sem_pkg::FH_W'(1));
	assign m_left   = (ocol_q == '0);
	assign m_right  = (EW'(ocol_q) == w_eff_q - EW'(1));

	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					if ((r == 0 && m_top) || (r == 2 && m_bottom) ||
					    (c == 0 && m_left) || (c == 2 && m_right)) begin
						v[r][c] = '0;
					end else begin
						v[r][c] = $signed({4'b0, win_q[r][c][(2-ch)*CH_W +: CH_W]});
					end
				end
			end
			gx_c[ch] = (v[0][2] + (v[1][2] <<< 1) + v[2][2]) -
			           (v[0][0] + (v[1][0] <<< 1) + v[2][0]);
			gy_c[ch] = (v[2][0] + (v[2][1] <<< 1) + v[2][2]) -
			           (v[0][0] + (v[0][1] <<< 1) + v[0][2]);
			try_c[ch]  = root_q[ch] | (CH_W'(1) << root_bit_q);
			prod_c[ch] = sem_pkg::PROD_W'(try_c[ch]) *
			             sem_pkg::PROD_W'(try_c[ch] - CH_W'(1));
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			up_rd_q  <= upper_mem[col_q];
			mid_rd_q <= middle_mem[col_q];
			op_q     <= in_op;
			px_q     <= in_px;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			upper_mem[col_q]  <= mid_rd_q;
			middle_mem[col_q] <= push_px;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.grad) begin
			gx_s1   <= gx_c;
			gy_s1   <= gy_c;
			last_s1 <= m_bottom && m_right;
		end
		if (ctl.square) begin
			for (int ch = 0; ch < 3; ch++) begin
				sum_s2[ch] <= sem_pkg::SUM_W'(gx_s1[ch] * gx_s1[ch]) +
				              sem_pkg::SUM_W'(gy_s1[ch] * gy_s1[ch]);
			end
		end
		if (ctl.eff) begin
			w_eff_q <= w_calc;
			h_eff_q <= h_calc;
		end
		if (ctl.mul) total_q <= TW'(w_eff_q * h_eff_q);
		if (ctl.load_out) begin
			out_red   <= root_q[0];
			out_green <= root_q[1];
			out_blue  <= root_q[2];
			out_last  <= last_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= sem_pkg::RESET_WIDTH;
			frame_height_q <= sem_pkg::RESET_HEIGHT;
			idx_q          <= '0;
			col_q          <= '0;
			pending_q      <= '0;
			orow_q         <= '0;
			ocol_q         <= '0;
			quo_q          <= '0;
			rem_q          <= '0;
			div_cnt_q      <= '0;
			root_bit_q     <= '0;
			out_valid_q    <= 1'b0;
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					win_q[r][c] <= '0;
				end
			end
			for (int ch = 0; ch < 3; ch++) begin
				root_q[ch] <= '0;
			end
		end else begin
			if (ctl.cfg_wr) begin
				if (cfg_index == sem_pkg::REG_FRAME_WIDTH) begin
					frame_width_q <= cfg_data[sem_pkg::FW_W-1:0];
				end else begin
					frame_height_q <= cfg_data;
				end
			end
			if (ctl.clamp) begin
				if (idx_q >= total_q) begin
					idx_q <= '0;
					quo_q <= '0;
				end else begin
					quo_q <= idx_q;
				end
				rem_q     <= '0;
				div_cnt_q <= '0;
				if (EW'(col_q) >= w_eff_q) col_q <= '0;
				if (pending_q > lag) pending_q <= lag;
			end
			if (ctl.div_step) begin
				quo_q     <= quo_n;
				rem_q     <= rem_n;
				div_cnt_q <= div_cnt_q + DCW'(1);
				if (stat.div_done) begin
					orow_q <= quo_n[sem_pkg::FH_W-1:0];
					ocol_q <= rem_n[CW-1:0];
				end
			end
			if (ctl.push) begin
				for (int r = 0; r < 3; r++) begin
					win_q[r][0] <= win_q[r][1];
					win_q[r][1] <= win_q[r][2];
				end
				win_q[0][2] <= up_rd_q;
				win_q[1][2] <= mid_rd_q;
				win_q[2][2] <= push_px;
				if (EW'(col_q) + EW'(1) == w_eff_q) col_q <= '0;
				else col_q <= col_q + CW'(1);
				if (op_q == sem_pkg::OP_DRAIN) pending_q <= pending_q - PW'(1);
				else if (pending_q != lag) pending_q <= pending_q + PW'(1);
			end
			if (ctl.grad) begin
				if (m_right) begin
					ocol_q <= '0;
					orow_q <= m_bottom ? '0 : orow_q + sem_pkg::FH_W'(1);
				end else begin
					ocol_q <= ocol_q + CW'(1);
				end
				idx_q <= (idx_q + TW'(1) == total_q) ? '0 : idx_q + TW'(1);
			end
			if (ctl.square) begin
				root_bit_q <= ($clog2(CH_W))'(sem_pkg::ROOT_LAST);
				for (int ch = 0; ch < 3; ch++) begin
					root_q[ch] <= '0;
				end
			end
			if (ctl.root_step) begin
				root_bit_q <= root_bit_q - ($clog2(CH_W))'(1);
				for (int ch = 0; ch < 3; ch++) begin
					if (sem_pkg::SUM_W'(prod_c[ch]) < sum_s2[ch]) root_q[ch] <= try_c[ch];
				end
			end
			if (ctl.load_out) out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready) out_valid_q <= 1'b0;
		end
	end

	assign stat.drain_skip = (in_op == sem_pkg::OP_DRAIN) && (pending_q == '0);
	assign stat.emit       = (op_q == sem_pkg::OP_DRAIN) || (pending_q == lag);
	assign stat.div_done   = (div_cnt_q == DCW'(TW - 1));
	assign stat.root_done  = (root_bit_q == '0);
	assign stat.out_free   = !out_valid_q || out_ready;
	assign out_valid       = out_valid_q;

endmodule

/* sv/sobel_edge_magnitude_rgb.sv */
// Top level of the RGB Sobel edge magnitude block.
// Input stream s_axis: one word per pixel in raster order; tuser 0 carries a pixel,
// tuser 1 is a drain word that pushes out one pending result (ignored if none pends).
// Output stream m_axis: one word per result, in raster order, one row and one pixel
// behind the input; tlast marks the result for the last pixel of a frame.
// After the last pixel of a frame, send frame_width+1 drain words, or simply
// start the next frame, whose first pixels push the previous results out.
// cfg: index 0 writes frame_width, index 1 frame_height; write while idle.
// A pixel word that yields no result only updates the window and line stores;
// a word that yields a result also goes through gradient, square, 8 steps of
// the root search (all channels at once) and output load, and only then is the
// next word taken. A config write recomputes the frame position by a bit-serial
// divider before input is taken again. Reset clears counters and window and runs
// that same recompute; the line stores are not cleared. A stalled receiver holds
// the result in the output register; the block keeps taking words until its next
// result is ready, then waits for it.
module sobel_edge_magnitude_rgb #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,   // in_red[7:0], in_green[15:8], in_blue[23:16]
	input  logic [0:0]  s_axis_tuser,   // op[0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // out_red[7:0], out_green[15:8], out_blue[23:16]
	output logic        m_axis_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);

	`include "sobel_edge_magnitude_rgb_assert.svh"

	sem_pkg::ctl_t  ctl;
	sem_pkg::stat_t stat;
	logic [sem_pkg::CH_W-1:0] out_red, out_green, out_blue;

	sem_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.cfg_valid (cfg_valid),
		.stat      (stat),
		.ctl       (ctl),
		.in_ready  (s_axis_tready),
		.cfg_ready (cfg_ready)
	);

	sem_dpath #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.stat      (stat),
		.in_op     (s_axis_tuser[0]),
		.in_px     ({s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tdata[23:16]}),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_red   (out_red),
		.out_green (out_green),
		.out_blue  (out_blue),
		.out_last  (m_axis_tlast),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready)
	);

	assign m_axis_tdata = {out_blue, out_green, out_red};

	`SEM_ASSERT_SAME(a_no_dual_accept, s_axis_tvalid && s_axis_tready, !(cfg_valid && cfg_ready), "input and config accepted together")
	`SEM_ASSERT_NEXT(a_cfg_blocks_input, cfg_valid && cfg_ready, !s_axis_tready, "input taken during recompute")
	`SEM_ASSERT_SAME(a_load_when_free, ctl.load_out, !m_axis_tvalid || m_axis_tready, "result overwrote a pending word")

endmodule
